// ===== design/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types, codes and a helper function of the task scheduler block.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int TASK_SLOTS  = 16;
  localparam int NTASK       = TASK_SLOTS + 1;
  localparam int PRIO_LEVELS = 8;
  localparam int ID_W        = $clog2(NTASK);
  localparam int SLOT_W      = $clog2(TASK_SLOTS);
  localparam int LV_W        = $clog2(PRIO_LEVELS);
  localparam int CNT_W       = $clog2(NTASK + 1);

  localparam logic [ID_W-1:0] IDLE_ID = ID_W'(TASK_SLOTS);
  localparam logic [15:0] SLICE_RESET = 16'd10;

  // Result status codes.
  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_ERR   = 2'd1;
  localparam logic [1:0] RES_INVAL = 2'd2;

  // Task states.
  localparam logic [2:0] TS_READY     = 3'd0;
  localparam logic [2:0] TS_RUNNING   = 3'd1;
  localparam logic [2:0] TS_BLOCKED   = 3'd2;
  localparam logic [2:0] TS_SUSPENDED = 3'd3;
  localparam logic [2:0] TS_DELETED   = 3'd4;

  typedef enum logic [3:0] {
    K_START, K_CREATE, K_DELETE, K_SUSPEND, K_RESUME, K_DELAY,
    K_YIELD, K_TICK, K_SCHEDULE, K_LOCK, K_UNLOCK
  } kind_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_EXEC, OP_ENQ, OP_DEQ, OP_WAKE,
    OP_TICKEND, OP_ROT, OP_SCHED2, OP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_FOLLOW, S_ENQ, S_DEQ, S_SWEEP,
    S_TICKEND, S_ROT, S_RENQ, S_SCHED2, S_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       flag;
    logic       go;
    logic       last;
  } dp_stat_t;

  // Highest set bit of the level bitmap, 0 when empty.
  function automatic logic [LV_W-1:0] highest_level(input logic [PRIO_LEVELS-1:0] bm);
    logic [LV_W-1:0] r;
    r = '0;
    for (int i = 0; i < PRIO_LEVELS; i++) begin
      if (bm[i]) r = LV_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== design/prs_cmd_if.sv =====
// ----------------------------------------------------------------------------
// prs_cmd_if
// Command channel of the task scheduler: valid, ready and one command.
// ----------------------------------------------------------------------------
interface prs_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [4:0]  target_task;
  logic [2:0]  prio_level;
  logic [31:0] delay_ticks;

  modport source (output valid, kind, target_task, prio_level, delay_ticks, input ready);
  modport sink (input valid, kind, target_task, prio_level, delay_ticks, output ready);
endinterface

// ===== design/prs_res_if.sv =====
// ----------------------------------------------------------------------------
// prs_res_if
// Result channel of the task scheduler: valid, ready and one result.
// ----------------------------------------------------------------------------
interface prs_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] created_task;
  logic [4:0] running_task;
  logic       running_valid;
  logic       switch_request;
  logic [7:0] ready_mask;

  modport source (output valid, status, created_task, running_task, running_valid,
                  switch_request, ready_mask, input ready);
  modport sink (input valid, status, created_task, running_task, running_valid,
                switch_request, ready_mask, output ready);
endinterface

// ===== design/prs_ctrl.sv =====
// ----------------------------------------------------------------------------
// prs_ctrl
// Sequencer: steps the datapath through the operations of one command.
// ----------------------------------------------------------------------------
module prs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  prs_pkg::dp_stat_t dp_stat_i,
  output prs_pkg::dp_cmd_t  dp_cmd_o
);

  prs_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dp_cmd_o.op = prs_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    unique case (state_q)
      prs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.op = prs_pkg::OP_LOAD;
          state_d     = prs_pkg::S_EXEC;
        end
      end
      prs_pkg::S_EXEC: begin
        dp_cmd_o.op = prs_pkg::OP_EXEC;
        state_d     = prs_pkg::S_FOLLOW;
      end
      prs_pkg::S_FOLLOW: begin
        case (dp_stat_i.kind)
          prs_pkg::K_CREATE, prs_pkg::K_RESUME:
            state_d = dp_stat_i.flag ? prs_pkg::S_ENQ : prs_pkg::S_DONE;
          prs_pkg::K_DELETE, prs_pkg::K_SUSPEND, prs_pkg::K_DELAY:
            state_d = dp_stat_i.flag ? prs_pkg::S_DEQ : prs_pkg::S_DONE;
          prs_pkg::K_TICK: state_d = prs_pkg::S_SWEEP;
          prs_pkg::K_SCHEDULE:
            state_d = dp_stat_i.flag ? prs_pkg::S_ROT :
                      (dp_stat_i.go ? prs_pkg::S_SCHED2 : prs_pkg::S_DONE);
          default: state_d = prs_pkg::S_DONE;
        endcase
      end
      prs_pkg::S_ENQ: begin
        dp_cmd_o.op = prs_pkg::OP_ENQ;
        state_d     = prs_pkg::S_DONE;
      end
      prs_pkg::S_DEQ: begin
        dp_cmd_o.op = prs_pkg::OP_DEQ;
        state_d     = prs_pkg::S_DONE;
      end
      prs_pkg::S_SWEEP: begin
        dp_cmd_o.op = prs_pkg::OP_WAKE;
        if (dp_stat_i.last) state_d = prs_pkg::S_TICKEND;
      end
      prs_pkg::S_TICKEND: begin
        dp_cmd_o.op = prs_pkg::OP_TICKEND;
        state_d     = prs_pkg::S_DONE;
      end
      prs_pkg::S_ROT: begin
        dp_cmd_o.op = prs_pkg::OP_ROT;
        state_d     = prs_pkg::S_RENQ;
      end
      prs_pkg::S_RENQ: begin
        dp_cmd_o.op = prs_pkg::OP_ENQ;
        state_d     = prs_pkg::S_SCHED2;
      end
      prs_pkg::S_SCHED2: begin
        dp_cmd_o.op = prs_pkg::OP_SCHED2;
        state_d     = prs_pkg::S_DONE;
      end
      prs_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.op = prs_pkg::OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = prs_pkg::S_IDLE;
        end
      end
      default: state_d = prs_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/prs_dp.sv =====
// ----------------------------------------------------------------------------
// prs_dp
// Datapath: task tables, level queues, time base and result registers.
// ----------------------------------------------------------------------------
module prs_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prs_pkg::dp_cmd_t  dp_cmd_i,
  output prs_pkg::dp_stat_t dp_stat_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [3:0]        kind_i,
  input  logic [4:0]        target_task_i,
  input  logic [2:0]        prio_level_i,
  input  logic [31:0]       delay_ticks_i,
  output logic [1:0]        status_o,
  output logic [4:0]        created_task_o,
  output logic [4:0]        running_task_o,
  output logic              running_valid_o,
  output logic              switch_request_o,
  output logic [7:0]        ready_mask_o
);

  localparam int IW = prs_pkg::ID_W;
  localparam int LW = prs_pkg::LV_W;
  localparam int CW = prs_pkg::CNT_W;
  localparam int NT = prs_pkg::NTASK;
  localparam int NS = prs_pkg::TASK_SLOTS;
  localparam int NL = prs_pkg::PRIO_LEVELS;
  localparam int SW = prs_pkg::SLOT_W;

  logic [15:0]   slice_cfg_q;
  logic          run_q;
  logic [7:0]    lock_q;
  logic [31:0]   now_q;
  logic [IW-1:0] cur_q;
  logic          present_q;
  logic [NS-1:0] used_q;
  logic [2:0]    stat_q    [NT];
  logic [LW-1:0] prio_q    [NT];
  logic [31:0]   wake_q    [NS];
  logic [15:0]   slice_q   [NT];
  logic [31:0]   runt_q    [NT];
  logic [IW-1:0] next_q    [NT];
  logic [IW-1:0] prev_q    [NT];
  logic [IW-1:0] head_q    [NL];
  logic [IW-1:0] tail_q    [NL];
  logic [CW-1:0] count_q   [NL];
  logic [NL-1:0] bitmap_q;

  // Latched command and working registers.
  logic [3:0]    kind_q;
  logic [4:0]    tgt_q;
  logic [LW-1:0] lvin_q;
  logic [31:0]   dly_q;
  logic [IW-1:0] t_q;
  logic          flag_q, go_q;
  logic [1:0]    status_q;
  logic [4:0]    created_q;
  logic          sw_q;

  // Result registers.
  logic [1:0]    res_status_q;
  logic [4:0]    res_created_q, res_running_q;
  logic          res_valid_q, res_sw_q;
  logic [7:0]    res_mask_q;

  logic [LW-1:0] lv, hi, cur_lv;
  logic [IW-1:0] p, n, tl, hd;
  logic [CW-1:0] cnt, cnt_dec;
  logic          wake_hit, do_enq, do_deq;
  logic          tgt_ok, tgt_inq, cur_inq;
  logic          free_any;
  logic [SW-1:0] free_idx;
  logic [31:0]   wake_diff;

  always_comb begin
    lv      = prio_q[t_q];
    p       = prev_q[t_q];
    n       = next_q[t_q];
    tl      = tail_q[lv];
    hd      = head_q[lv];
    cnt     = count_q[lv];
    cnt_dec = (cnt != '0) ? cnt - CW'(1) : '0;
    hi      = prs_pkg::highest_level(bitmap_q);
    cur_lv  = prio_q[cur_q];
    wake_diff = now_q - wake_q[t_q[SW-1:0]];
    wake_hit = used_q[t_q[SW-1:0]] && (stat_q[t_q] == prs_pkg::TS_BLOCKED) &&
               !wake_diff[31];
    do_enq  = (dp_cmd_i.op == prs_pkg::OP_ENQ) ||
              ((dp_cmd_i.op == prs_pkg::OP_WAKE) && wake_hit);
    do_deq  = (dp_cmd_i.op == prs_pkg::OP_DEQ) || (dp_cmd_i.op == prs_pkg::OP_ROT);
    tgt_ok  = (tgt_q < 5'(NT)) && ((tgt_q == 5'(prs_pkg::IDLE_ID)) || used_q[tgt_q[SW-1:0]]);
    tgt_inq = (stat_q[tgt_q[IW-1:0]] == prs_pkg::TS_READY) ||
              (stat_q[tgt_q[IW-1:0]] == prs_pkg::TS_RUNNING);
    cur_inq = (stat_q[cur_q] == prs_pkg::TS_READY) || (stat_q[cur_q] == prs_pkg::TS_RUNNING);
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign dp_stat_o.kind = kind_q;
  assign dp_stat_o.flag = flag_q;
  assign dp_stat_o.go   = go_q;
  assign dp_stat_o.last = (t_q == IW'(NS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_cfg_q <= prs_pkg::SLICE_RESET;
      run_q       <= 1'b0;
      lock_q      <= '0;
      now_q       <= '0;
      cur_q       <= prs_pkg::IDLE_ID;
      present_q   <= 1'b1;
      used_q      <= '0;
      // Only the idle task is queued, alone at level 0.
      for (int i = 0; i < NT; i++) begin
        stat_q[i]  <= (i == int'(prs_pkg::IDLE_ID)) ? prs_pkg::TS_READY : prs_pkg::TS_DELETED;
        prio_q[i]  <= '0;
        slice_q[i] <= (i == int'(prs_pkg::IDLE_ID)) ? prs_pkg::SLICE_RESET : '0;
        runt_q[i]  <= '0;
        next_q[i]  <= '0;
        prev_q[i]  <= '0;
      end
      for (int i = 0; i < NL; i++) begin
        head_q[i]  <= (i == 0) ? prs_pkg::IDLE_ID : '0;
        tail_q[i]  <= (i == 0) ? prs_pkg::IDLE_ID : '0;
        count_q[i] <= (i == 0) ? CW'(1) : '0;
      end
      bitmap_q   <= NL'(1);
      flag_q     <= 1'b0;
      go_q       <= 1'b0;
    end else begin
      if (cfg_we_i) slice_cfg_q <= cfg_data_i;

      // Append task t_q to the tail of its level queue.
      if (do_enq) begin
        if (cnt != '0) begin
          next_q[tl]  <= t_q;
          prev_q[t_q] <= tl;
        end else begin
          head_q[lv]  <= t_q;
          prev_q[t_q] <= '0;
        end
        next_q[t_q]  <= '0;
        tail_q[lv]   <= t_q;
        count_q[lv]  <= cnt + CW'(1);
        bitmap_q[lv] <= 1'b1;
        stat_q[t_q]  <= prs_pkg::TS_READY;
      end

      // Unlink task t_q from its level queue.
      if (do_deq) begin
        if (hd == t_q) head_q[lv] <= n;
        else next_q[p] <= n;
        if (tl == t_q) tail_q[lv] <= p;
        else prev_q[n] <= p;
        count_q[lv] <= cnt_dec;
        if (cnt_dec == '0) bitmap_q[lv] <= 1'b0;
        next_q[t_q] <= '0;
        prev_q[t_q] <= '0;
        if (dp_cmd_i.op == prs_pkg::OP_ROT) slice_q[t_q] <= slice_cfg_q;
      end

      case (dp_cmd_i.op)
        prs_pkg::OP_LOAD: begin
          kind_q    <= kind_i;
          tgt_q     <= target_task_i;
          lvin_q    <= prio_level_i;
          dly_q     <= delay_ticks_i;
          t_q       <= target_task_i[IW-1:0];
          status_q  <= prs_pkg::RES_OK;
          created_q <= '0;
          sw_q      <= 1'b0;
          flag_q    <= 1'b0;
          go_q      <= 1'b0;
        end
        prs_pkg::OP_EXEC: begin
          case (kind_q)
            prs_pkg::K_START: begin
              if (!run_q) begin
                if (count_q[hi] != '0) begin
                  cur_q                <= head_q[hi];
                  present_q            <= 1'b1;
                  stat_q[head_q[hi]]   <= prs_pkg::TS_RUNNING;
                  run_q                <= 1'b1;
                end else begin
                  status_q <= prs_pkg::RES_ERR;
                end
              end
            end
            prs_pkg::K_CREATE: begin
              if (!free_any) begin
                status_q <= prs_pkg::RES_ERR;
              end else begin
                used_q[free_idx]  <= 1'b1;
                prio_q[free_idx]  <= lvin_q;
                slice_q[free_idx] <= slice_cfg_q;
                runt_q[free_idx]  <= '0;
                wake_q[free_idx]  <= '0;
                t_q               <= IW'(free_idx);
                created_q         <= 5'(free_idx);
                flag_q            <= 1'b1;
              end
            end
            prs_pkg::K_DELETE, prs_pkg::K_SUSPEND: begin
              if (!tgt_ok || (tgt_q == 5'(prs_pkg::IDLE_ID))) begin
                status_q <= prs_pkg::RES_INVAL;
              end else begin
                flag_q <= tgt_inq;
                if (present_q && (tgt_q[IW-1:0] == cur_q)) sw_q <= 1'b1;
                if (kind_q == prs_pkg::K_DELETE) begin
                  stat_q[tgt_q[IW-1:0]] <= prs_pkg::TS_DELETED;
                  used_q[tgt_q[SW-1:0]] <= 1'b0;
                  if (present_q && (tgt_q[IW-1:0] == cur_q)) present_q <= 1'b0;
                end else if (tgt_inq) begin
                  stat_q[tgt_q[IW-1:0]] <= prs_pkg::TS_SUSPENDED;
                end
              end
            end
            prs_pkg::K_RESUME: begin
              if (!tgt_ok) status_q <= prs_pkg::RES_INVAL;
              else flag_q <= (stat_q[tgt_q[IW-1:0]] == prs_pkg::TS_SUSPENDED);
            end
            prs_pkg::K_DELAY: begin
              if (run_q && present_q && (dly_q != '0)) begin
                if ((cur_q == prs_pkg::IDLE_ID) || !cur_inq) begin
                  status_q <= prs_pkg::RES_ERR;
                end else begin
                  wake_q[cur_q[SW-1:0]] <= now_q + dly_q;
                  stat_q[cur_q]         <= prs_pkg::TS_BLOCKED;
                  sw_q                  <= 1'b1;
                  t_q                   <= cur_q;
                  flag_q                <= 1'b1;
                end
              end
            end
            prs_pkg::K_YIELD: begin
              if (run_q && present_q) begin
                slice_q[cur_q] <= slice_cfg_q;
                sw_q           <= 1'b1;
              end
            end
            prs_pkg::K_TICK: begin
              now_q <= now_q + 32'd1;
              if (run_q && present_q) begin
                if (slice_q[cur_q] != '0) slice_q[cur_q] <= slice_q[cur_q] - 16'd1;
                runt_q[cur_q] <= runt_q[cur_q] + 32'd1;
              end
              t_q <= '0;
            end
            prs_pkg::K_SCHEDULE: begin
              if (run_q && (lock_q == '0)) begin
                if (count_q[hi] == '0) begin
                  cur_q     <= prs_pkg::IDLE_ID;
                  present_q <= 1'b1;
                end else begin
                  t_q  <= cur_q;
                  go_q <= 1'b1;
                  flag_q <= (count_q[hi] > CW'(1)) && present_q &&
                            (head_q[hi] == cur_q) && (slice_q[cur_q] == '0);
                end
              end
            end
            prs_pkg::K_LOCK: begin
              if (lock_q != 8'hFF) lock_q <= lock_q + 8'd1;
            end
            prs_pkg::K_UNLOCK: begin
              if (lock_q != '0) lock_q <= lock_q - 8'd1;
            end
            default: status_q <= prs_pkg::RES_INVAL;
          endcase
        end
        prs_pkg::OP_WAKE: t_q <= t_q + IW'(1);
        prs_pkg::OP_TICKEND: begin
          if (run_q && (lock_q == '0) && present_q) begin
            if (((slice_q[cur_q] == '0) && (count_q[cur_lv] > CW'(1))) || (hi > cur_lv))
              sw_q <= 1'b1;
          end
        end
        prs_pkg::OP_SCHED2: begin
          if (!present_q || (head_q[hi] != cur_q)) begin
            if (present_q && (stat_q[cur_q] == prs_pkg::TS_RUNNING))
              stat_q[cur_q] <= prs_pkg::TS_READY;
            cur_q              <= head_q[hi];
            present_q          <= 1'b1;
            stat_q[head_q[hi]] <= prs_pkg::TS_RUNNING;
          end
        end
        default: ;
      endcase
    end
  end

  // Result registers hold the last result until the next one is loaded.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == prs_pkg::OP_FINISH) begin
      res_status_q  <= status_q;
      res_created_q <= created_q;
      res_running_q <= present_q ? 5'(cur_q) : '0;
      res_valid_q   <= present_q;
      res_sw_q      <= sw_q;
      res_mask_q    <= 8'(bitmap_q);
    end
  end

  assign status_o         = res_status_q;
  assign created_task_o   = res_created_q;
  assign running_task_o   = res_running_q;
  assign running_valid_o  = res_valid_q;
  assign switch_request_o = res_sw_q;
  assign ready_mask_o     = res_mask_q;

endmodule

// ===== design/priority_round_robin_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_unit
// Priority task scheduler with round-robin time slices, one result per command.
// ----------------------------------------------------------------------------
// Commands arrive on cmd_i and each gives exactly one result on res_o; a
// transfer happens when valid and ready are both high at a rising edge.
// The time slice length is written through cfg_we_i and cfg_data_i; the user
// must do so only while the block is idle, as the block does not enforce it.
// Each command runs the load, execute and follow-up steps; create, delete,
// suspend, resume and delay add an enqueue or dequeue step when they touch a
// queue, schedule may add rotate, re-enqueue and second scheduling steps, and
// tick adds a wake-up check that walks the sixteen task slots one per cycle in
// the datapath. Commands are processed one at a time, so the next command is
// taken once the previous one has reached the result register.
// A result waiting on a stalled receiver does not block the next command;
// only the following result waits until the stalled one has been taken.
// Reset leaves only the idle task queued at level 0, the scheduler stopped,
// the slice length at 10 and no result pending.
// ----------------------------------------------------------------------------
module priority_round_robin_task_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  prs_cmd_if.sink     cmd_i,
  prs_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  prs_pkg::dp_cmd_t  dp_cmd;
  prs_pkg::dp_stat_t dp_stat;

  // Sequencer: decides which datapath operation runs in each cycle.
  prs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .dp_stat_i   (dp_stat),
    .dp_cmd_o    (dp_cmd)
  );

  // Datapath: task tables, linked level queues and the result register.
  prs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dp_cmd_i         (dp_cmd),
    .dp_stat_o        (dp_stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .kind_i           (cmd_i.kind),
    .target_task_i    (cmd_i.target_task),
    .prio_level_i     (cmd_i.prio_level),
    .delay_ticks_i    (cmd_i.delay_ticks),
    .status_o         (res_o.status),
    .created_task_o   (res_o.created_task),
    .running_task_o   (res_o.running_task),
    .running_valid_o  (res_o.running_valid),
    .switch_request_o (res_o.switch_request),
    .ready_mask_o     (res_o.ready_mask)
  );

endmodule

// ===== tb/prs_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_tb_pkg
// Scheduler state predictor and result scoreboard for the task scheduler bench.
// ----------------------------------------------------------------------------
package prs_tb_pkg;
  import prs_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] created_task;
    logic [4:0] running_task;
    logic       running_valid;
    logic       switch_request;
    logic [7:0] ready_mask;
  } sched_res_t;

  class sched_scoreboard;
    logic [15:0] slice_len;
    bit          started;
    int unsigned lock_cnt;
    logic [31:0] now;
    int unsigned cur;
    bit          cur_ok;
    bit          used[TASK_SLOTS];
    logic [2:0]  tstate[NTASK];
    int unsigned tprio[NTASK];
    logic [31:0] wake[TASK_SLOTS];
    logic [15:0] slice[NTASK];
    int unsigned nxt[NTASK];
    int unsigned prv[NTASK];
    int unsigned head[PRIO_LEVELS];
    int unsigned tail[PRIO_LEVELS];
    int unsigned cnt[PRIO_LEVELS];
    logic [7:0]  bitmap;
    sched_res_t  pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned switches;
    int unsigned creates_ok;

    function new();
      errors = 0;
      checked = 0;
      switches = 0;
      creates_ok = 0;
      slice_len = SLICE_RESET;
      started = 0;
      lock_cnt = 0;
      now = 0;
      cur = TASK_SLOTS;
      cur_ok = 1;
      bitmap = 0;
      for (int i = 0; i < NTASK; i++) begin
        tstate[i] = TS_DELETED;
        tprio[i] = 0;
        slice[i] = 0;
        nxt[i] = 0;
        prv[i] = 0;
        if (i < TASK_SLOTS) begin
          used[i] = 0;
          wake[i] = 0;
        end
      end
      for (int l = 0; l < PRIO_LEVELS; l++) begin
        head[l] = 0;
        tail[l] = 0;
        cnt[l] = 0;
      end
      slice[TASK_SLOTS] = slice_len;
      link_in(TASK_SLOTS);
    endfunction

    function bit queued(int unsigned t);
      return tstate[t] == TS_READY || tstate[t] == TS_RUNNING;
    endfunction

    function void link_in(int unsigned t);
      int unsigned lv;
      lv = tprio[t];
      if (cnt[lv] > 0) begin
        nxt[tail[lv]] = t;
        prv[t] = tail[lv];
      end else begin
        head[lv] = t;
        prv[t] = 0;
      end
      nxt[t] = 0;
      tail[lv] = t;
      cnt[lv]++;
      bitmap[lv] = 1'b1;
      tstate[t] = TS_READY;
    endfunction

    function void unlink(int unsigned t);
      int unsigned lv, p, n;
      lv = tprio[t];
      p = prv[t];
      n = nxt[t];
      if (head[lv] == t) head[lv] = n;
      else next_fix(p, n);
      if (tail[lv] == t) tail[lv] = p;
      else prv[n] = p;
      if (cnt[lv] > 0) cnt[lv]--;
      if (cnt[lv] == 0) bitmap[lv] = 1'b0;
      nxt[t] = 0;
      prv[t] = 0;
    endfunction

    function void next_fix(int unsigned p, int unsigned n);
      nxt[p] = n;
    endfunction

    function int unsigned top_level();
      for (int i = PRIO_LEVELS - 1; i >= 0; i--) if (bitmap[i]) return i;
      return 0;
    endfunction

    // Advances the scheduler state by one command and queues the expected result.
    function void note_command(logic [3:0] kind, logic [4:0] tgt, logic [2:0] prio,
                               logic [31:0] dly);
      sched_res_t r;
      int unsigned h, hd, i;
      bit tgt_ok;
      r = '0;
      tgt_ok = tgt < NTASK && (tgt == TASK_SLOTS || used[tgt]);
      case (kind)
        K_START: begin
          if (!started) begin
            h = top_level();
            if (cnt[h] > 0) begin
              cur = head[h];
              cur_ok = 1;
              tstate[cur] = TS_RUNNING;
              started = 1;
            end else r.status = RES_ERR;
          end
        end
        K_CREATE: begin
          for (i = 0; i < TASK_SLOTS; i++) if (!used[i]) break;
          if (i >= TASK_SLOTS) r.status = RES_ERR;
          else begin
            used[i] = 1;
            tprio[i] = prio;
            slice[i] = slice_len;
            wake[i] = 0;
            link_in(i);
            r.created_task = 5'(i);
            creates_ok++;
          end
        end
        K_DELETE, K_SUSPEND: begin
          if (!tgt_ok || tgt == TASK_SLOTS) r.status = RES_INVAL;
          else if (kind == K_DELETE) begin
            if (queued(tgt)) unlink(tgt);
            tstate[tgt] = TS_DELETED;
            used[tgt] = 0;
            if (cur_ok && tgt == cur) begin
              cur_ok = 0;
              r.switch_request = 1;
            end
          end else begin
            if (queued(tgt)) begin
              unlink(tgt);
              tstate[tgt] = TS_SUSPENDED;
            end
            if (cur_ok && tgt == cur) r.switch_request = 1;
          end
        end
        K_RESUME: begin
          if (!tgt_ok) r.status = RES_INVAL;
          else if (tstate[tgt] == TS_SUSPENDED) link_in(tgt);
        end
        K_DELAY: begin
          if (started && cur_ok && dly != 0) begin
            if (cur == TASK_SLOTS || !queued(cur)) r.status = RES_ERR;
            else begin
              wake[cur] = now + dly;
              unlink(cur);
              tstate[cur] = TS_BLOCKED;
              r.switch_request = 1;
            end
          end
        end
        K_YIELD: begin
          if (started && cur_ok) begin
            slice[cur] = slice_len;
            r.switch_request = 1;
          end
        end
        K_TICK: begin
          now++;
          if (started && cur_ok && slice[cur] > 0) slice[cur]--;
          for (i = 0; i < TASK_SLOTS; i++) begin
            logic [31:0] d;
            d = now - wake[i];
            if (used[i] && tstate[i] == TS_BLOCKED && !d[31]) link_in(i);
          end
          if (started && lock_cnt == 0 && cur_ok) begin
            h = top_level();
            if (slice[cur] == 0 && cnt[tprio[cur]] > 1) r.switch_request = 1;
            if (h > tprio[cur]) r.switch_request = 1;
          end
        end
        K_SCHEDULE: begin
          if (started && lock_cnt == 0) begin
            h = top_level();
            if (cnt[h] == 0) begin
              cur = TASK_SLOTS;
              cur_ok = 1;
            end else begin
              hd = head[h];
              if (cnt[h] > 1 && cur_ok && hd == cur && slice[cur] == 0) begin
                unlink(cur);
                slice[cur] = slice_len;
                link_in(cur);
                hd = head[h];
              end
              if (!cur_ok || hd != cur) begin
                if (cur_ok && tstate[cur] == TS_RUNNING) tstate[cur] = TS_READY;
                cur = hd;
                cur_ok = 1;
                tstate[hd] = TS_RUNNING;
              end
            end
          end
        end
        K_LOCK: if (lock_cnt < 255) lock_cnt++;
        K_UNLOCK: if (lock_cnt > 0) lock_cnt--;
        default: r.status = RES_INVAL;
      endcase
      r.running_task = cur_ok ? 5'(cur) : 5'd0;
      r.running_valid = cur_ok;
      r.ready_mask = bitmap;
      if (r.switch_request) switches++;
      pending.push_back(r);
    endfunction

    function void check_result(sched_res_t act);
      sched_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.status != act.status)
        $display("%0t: status exp %0d act %0d", $time, e.status, act.status);
      if (e.created_task != act.created_task)
        $display("%0t: created_task exp %0d act %0d", $time, e.created_task,
                 act.created_task);
      if (e.running_task != act.running_task)
        $display("%0t: running_task exp %0d act %0d", $time, e.running_task,
                 act.running_task);
      if (e.running_valid != act.running_valid)
        $display("%0t: running_valid exp %0d act %0d", $time, e.running_valid,
                 act.running_valid);
      if (e.switch_request != act.switch_request)
        $display("%0t: switch_request exp %0d act %0d", $time, e.switch_request,
                 act.switch_request);
      if (e.ready_mask != act.ready_mask)
        $display("%0t: ready_mask exp %h act %h", $time, e.ready_mask, act.ready_mask);
      if (e != act) errors++;
    endfunction
  endclass
endpackage

// ===== tb/tb_priority_round_robin_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_priority_round_robin_task_scheduler_unit
// Self-checking bench: drives commands with random bursts and gaps, stalls the
// result side, and compares every result with a cycle-free state predictor.
// ----------------------------------------------------------------------------
module tb_priority_round_robin_task_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import prs_pkg::*;
  import prs_tb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  int unsigned cycle_count = 0;
  bit          hold_off = 0;
  bit          stall_on = 1;
  int unsigned long_holds = 0;

  prs_cmd_if cmd ();
  prs_res_if res ();

  sched_scoreboard board;

  priority_round_robin_task_scheduler_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd.sink),
    .res_o      (res.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // The limit covers the slowest legal run: about 1000 commands, each at most a
  // full tick sweep, plus sender gaps, receiver stalls and the long hold-off.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: every transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      board.check_result({res.status, res.created_task, res.running_task,
                          res.running_valid, res.switch_request, res.ready_mask});
    end
  end

  // Receiver stall pattern. A hold-off forces ready low for a long stretch so
  // that the result register stays full and the command input is stalled.
  always @(posedge clk_i) begin
    if (!rst_ni) res.ready <= 1'b0;
    else if (hold_off) res.ready <= 1'b0;
    else if (!stall_on) res.ready <= 1'b1;
    else res.ready <= ($urandom_range(0, 3) != 0);
  end

  // Offers one command and waits for its transfer.
  task automatic send_command(logic [3:0] kind, logic [4:0] tgt, logic [2:0] prio,
                              logic [31:0] dly);
    cmd.valid <= 1'b1;
    cmd.kind <= kind;
    cmd.target_task <= tgt;
    cmd.prio_level <= prio;
    cmd.delay_ticks <= dly;
    do @(posedge clk_i); while (!cmd.ready);
    board.note_command(kind, tgt, prio, dly);
  endtask

  task automatic pause_sender();
    cmd.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // Waits for every expected result, then allows the longest command time.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    cmd.valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_slice(logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.slice_len = val;
  endtask

  // Random command mix weighted towards well-formed scheduling activity:
  // plenty of ticks, schedules and creates, occasional bad targets.
  task automatic random_command();
    logic [3:0]  kind;
    logic [4:0]  tgt;
    logic [31:0] dly;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) kind = K_TICK;
    else if (pick < 40) kind = K_SCHEDULE;
    else if (pick < 50) kind = K_CREATE;
    else if (pick < 57) kind = K_DELAY;
    else if (pick < 62) kind = K_YIELD;
    else if (pick < 68) kind = K_SUSPEND;
    else if (pick < 76) kind = K_RESUME;
    else if (pick < 82) kind = K_DELETE;
    else if (pick < 86) kind = K_LOCK;
    else if (pick < 91) kind = K_UNLOCK;
    else if (pick < 94) kind = K_START;
    else kind = $urandom_range(11, 15);
    tgt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                      : 5'($urandom_range(0, TASK_SLOTS));
    case ($urandom_range(0, 5))
      0: dly = $urandom;
      1: dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: dly = $urandom_range(0, 6);
    endcase
    send_command(kind, tgt, 3'($urandom_range(0, 7)), dly);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned burst;
    int unsigned k;
    k = 0;
    while (k < n) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        random_command();
        k++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    drain();
  endtask

  initial begin
    cmd.valid = 1'b0;
    cmd.kind = '0;
    cmd.target_task = '0;
    cmd.prio_level = '0;
    cmd.delay_ticks = '0;
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every command, bad and idle targets, commands before start.
    write_slice(16'd1);
    send_command(K_YIELD, 5'd0, 3'd0, 32'd0);
    send_command(K_DELAY, 5'd0, 3'd0, 32'd5);
    send_command(K_SCHEDULE, 5'd0, 3'd0, 32'd0);
    send_command(K_START, 5'd0, 3'd0, 32'd0);
    send_command(K_DELAY, 5'd0, 3'd0, 32'd3);
    send_command(K_DELETE, 5'(TASK_SLOTS), 3'd0, 32'd0);
    send_command(K_SUSPEND, 5'(TASK_SLOTS), 3'd0, 32'd0);
    send_command(K_RESUME, 5'(TASK_SLOTS), 3'd0, 32'd0);
    send_command(K_DELETE, 5'd31, 3'd0, 32'd0);
    send_command(K_RESUME, 5'd3, 3'd0, 32'd0);
    send_command(K_CREATE, 5'd0, 3'd7, 32'd0);
    send_command(K_CREATE, 5'd0, 3'd7, 32'd0);
    send_command(K_TICK, 5'd0, 3'd0, 32'd0);
    send_command(K_SCHEDULE, 5'd0, 3'd0, 32'd0);
    send_command(K_TICK, 5'd0, 3'd0, 32'd0);
    send_command(K_SCHEDULE, 5'd0, 3'd0, 32'd0);
    send_command(K_DELAY, 5'd0, 3'd0, 32'hFFFF_FFFF);
    send_command(K_SUSPEND, 5'd0, 3'd0, 32'd0);
    send_command(K_RESUME, 5'd0, 3'd0, 32'd0);
    send_command(K_DELETE, 5'd1, 3'd0, 32'd0);
    send_command(K_LOCK, 5'd0, 3'd0, 32'd0);
    send_command(K_SCHEDULE, 5'd0, 3'd0, 32'd0);
    send_command(K_UNLOCK, 5'd0, 3'd0, 32'd0);
    send_command(K_UNLOCK, 5'd0, 3'd0, 32'd0);
    send_command(4'd15, 5'd0, 3'd0, 32'd0);
    drain();

    // Saturate the lock counter, fill every slot, then back-pressure.
    repeat (260) send_command(K_LOCK, 5'd0, 3'd0, 32'd0);
    repeat (258) send_command(K_UNLOCK, 5'd0, 3'd0, 32'd0);
    repeat (18) send_command(K_CREATE, 5'd0, 3'($urandom_range(0, 7)), 32'd0);
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
        long_holds++;
      end
      repeat (10) send_command(K_SCHEDULE, 5'd0, 3'd0, 32'd0);
    join
    drain();

    write_slice(16'hFFFF);
    random_phase(100);
    write_slice(16'd2);
    stall_on = 0;
    random_phase(80);
    stall_on = 1;
    write_slice(16'd10);
    random_phase(100);
    write_slice(16'd1);
    random_phase(100);

    $display("Checked %0d results, %0d switch requests, %0d successful creates;",
             board.checked, board.switches, board.creates_ok);
    $display("slice lengths 1, 2, 10 and 65535, lock saturation, %0d long hold-off.",
             long_holds);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/prs_pkg.sv
design/prs_cmd_if.sv
design/prs_res_if.sv
design/prs_ctrl.sv
design/prs_dp.sv
design/priority_round_robin_task_scheduler_unit.sv
tb/prs_tb_pkg.sv
tb/tb_priority_round_robin_task_scheduler_unit.sv
